@@ rtl/core/dbc_pkg.sv @@
// ----------------------------------------------------------------------------
// dbc_pkg
// shared types and constants of the dkim body canonicalizer
// ----------------------------------------------------------------------------
package dbc_pkg;

    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    // input commands
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // output item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    // slots of a bundle, in output order
    localparam int unsigned SLOT_RUN   = 0;
    localparam int unsigned SLOT_SP    = 1;
    localparam int unsigned SLOT_CR    = 2;
    localparam int unsigned SLOT_DATA  = 3;
    localparam int unsigned SLOT_LAST  = 4;
    localparam int unsigned SLOT_COUNT = 5;

    typedef logic [SLOT_COUNT-1:0] t_slots;

    // everything one accepted input item causes
    typedef struct packed {
        t_slots             slots;
        logic [COUNT_W-1:0] run_count;
        logic [7:0]         data;
    } t_bundle;

endpackage

@@ rtl/core/dbc_front.sv @@
// ----------------------------------------------------------------------------
// dbc_front
// classifies body bytes, keeps line state and builds output bundles
// ----------------------------------------------------------------------------
module dbc_front #(
    parameter int unsigned CNT_W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_write,
    input  logic              i_cfg_data,
    input  logic              i_accept,
    input  logic              i_command,
    input  logic [7:0]        i_data_byte,
    output logic              o_push,
    output dbc_pkg::t_bundle  o_bundle
);

    localparam logic [CNT_W-1:0] CAP = '1;

    logic             r_relaxed,  n_relaxed;
    logic             r_pending,  n_pending;
    logic             r_held_cr,  n_held_cr;
    logic             r_content,  n_content;
    logic [CNT_W-1:0] r_owed,     n_owed;

    dbc_pkg::t_bundle bnd;

    always_comb begin
        logic ws;
        logic owe;
        ws        = (i_data_byte == dbc_pkg::CH_SP) || (i_data_byte == dbc_pkg::CH_TAB);
        n_relaxed = i_cfg_write ? i_cfg_data : r_relaxed;
        n_pending = r_pending;
        n_held_cr = r_held_cr;
        n_content = r_content;
        n_owed    = r_owed;
        bnd       = '0;
        owe       = 1'b0;

        if (i_accept) begin
            if (i_command == dbc_pkg::CMD_END) begin
                if (r_held_cr) begin
                    bnd.slots[dbc_pkg::SLOT_RUN] = (r_owed != '0);
                    bnd.run_count                = dbc_pkg::COUNT_W'(r_owed);
                    bnd.slots[dbc_pkg::SLOT_SP]  = r_pending;
                    bnd.slots[dbc_pkg::SLOT_CR]  = 1'b1;
                end
                bnd.slots[dbc_pkg::SLOT_LAST] = r_held_cr || r_content || !r_relaxed;
                n_pending = 1'b0;
                n_held_cr = 1'b0;
                n_content = 1'b0;
                n_owed    = '0;
            end else if (r_held_cr && (i_data_byte == dbc_pkg::CH_LF)) begin
                // line end: trailing space dropped, one more break owed
                n_held_cr = 1'b0;
                n_pending = 1'b0;
                if (r_owed != CAP) begin
                    n_owed = r_owed + 1'b1;
                end
            end else begin
                owe = (r_owed != '0);
                bnd.run_count = dbc_pkg::COUNT_W'(r_owed);
                if (r_held_cr) begin
                    // lone cr is content
                    bnd.slots[dbc_pkg::SLOT_RUN] = owe;
                    bnd.slots[dbc_pkg::SLOT_SP]  = r_pending;
                    bnd.slots[dbc_pkg::SLOT_CR]  = 1'b1;
                    n_held_cr = 1'b0;
                    n_pending = 1'b0;
                    n_owed    = '0;
                    n_content = 1'b1;
                end
                if (i_data_byte == dbc_pkg::CH_CR) begin
                    n_held_cr = 1'b1;
                end else if (r_relaxed && ws) begin
                    n_pending = 1'b1;
                end else begin
                    bnd.slots[dbc_pkg::SLOT_RUN]  = (n_owed != '0) || bnd.slots[dbc_pkg::SLOT_RUN];
                    bnd.slots[dbc_pkg::SLOT_SP]   = n_pending || bnd.slots[dbc_pkg::SLOT_SP];
                    bnd.slots[dbc_pkg::SLOT_DATA] = 1'b1;
                    bnd.data  = i_data_byte;
                    n_pending = 1'b0;
                    n_owed    = '0;
                    n_content = 1'b1;
                end
            end
        end
    end

    assign o_push   = i_accept && (bnd.slots != '0);
    assign o_bundle = bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relaxed <= 1'b1;
            r_pending <= 1'b0;
            r_held_cr <= 1'b0;
            r_content <= 1'b0;
            r_owed    <= '0;
        end else begin
            r_relaxed <= n_relaxed;
            r_pending <= n_pending;
            r_held_cr <= n_held_cr;
            r_content <= n_content;
            r_owed    <= n_owed;
        end
    end

endmodule

@@ rtl/core/dbc_queue.sv @@
// ----------------------------------------------------------------------------
// dbc_queue
// short bundle queue between front and back
// ----------------------------------------------------------------------------
module dbc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dbc_pkg::t_bundle  i_bundle,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output dbc_pkg::t_bundle  o_head
);

    dbc_pkg::t_bundle r_mem [dbc_pkg::QUEUE_DEPTH];

    logic [dbc_pkg::QPTR_W-1:0] r_wr, n_wr;
    logic [dbc_pkg::QPTR_W-1:0] r_rd, n_rd;
    logic [dbc_pkg::QCNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == dbc_pkg::QCNT_W'(dbc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    property p_no_overflow;
        @(posedge i_clk) disable iff (!i_rst_n) o_full |-> !(i_push && !i_pop);
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

    property p_no_underflow;
        @(posedge i_clk) disable iff (!i_rst_n) i_pop |-> !o_empty;
    endproperty
    a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

endmodule

@@ rtl/core/dbc_back.sv @@
// ----------------------------------------------------------------------------
// dbc_back
// walks the slots of the head bundle, one output item per transfer
// ----------------------------------------------------------------------------
module dbc_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  dbc_pkg::t_bundle             i_head,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_item_kind,
    output logic [7:0]                   o_out_byte,
    output logic [dbc_pkg::COUNT_W-1:0]  o_break_count,
    output logic                         o_is_last
);

    dbc_pkg::t_slots r_sent, n_sent;
    dbc_pkg::t_slots remain, pick;

    logic                        r_valid, n_valid;
    logic                        r_kind,  n_kind;
    logic [7:0]                  r_data,  n_data;
    logic [dbc_pkg::COUNT_W-1:0] r_count, n_count;
    logic                        r_last,  n_last;
    logic                        load;

    assign remain = i_empty ? '0 : (i_head.slots & ~r_sent);
    assign pick   = remain & (~remain + 1'b1);   // lowest pending slot
    assign load   = !r_valid || !i_out_stall;
    assign o_pop  = load && (remain != '0) && ((remain & ~pick) == '0);

    always_comb begin
        n_valid = r_valid;
        n_kind  = r_kind;
        n_data  = r_data;
        n_count = r_count;
        n_last  = r_last;
        n_sent  = r_sent;
        if (load) begin
            n_valid = (remain != '0);
            n_kind  = dbc_pkg::KIND_BYTE;
            n_data  = '0;
            n_count = '0;
            n_last  = 1'b0;
            if (pick[dbc_pkg::SLOT_RUN]) begin
                n_kind  = dbc_pkg::KIND_RUN;
                n_count = i_head.run_count;
            end else if (pick[dbc_pkg::SLOT_SP]) begin
                n_data = dbc_pkg::CH_SP;
            end else if (pick[dbc_pkg::SLOT_CR]) begin
                n_data = dbc_pkg::CH_CR;
            end else if (pick[dbc_pkg::SLOT_DATA]) begin
                n_data = i_head.data;
            end else if (pick[dbc_pkg::SLOT_LAST]) begin
                n_kind  = dbc_pkg::KIND_RUN;
                n_count = dbc_pkg::COUNT_W'(1);
                n_last  = 1'b1;
            end
            if (o_pop) begin
                n_sent = '0;
            end else begin
                n_sent = r_sent | pick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_data  <= n_data;
        r_count <= n_count;
        r_last  <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sent  <= '0;
        end else begin
            r_valid <= n_valid;
            r_sent  <= n_sent;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_item_kind   = r_kind;
    assign o_out_byte    = r_data;
    assign o_break_count = r_count;
    assign o_is_last     = r_last;

endmodule

@@ rtl/core/dkim_body_canonicalizer.sv @@
// ----------------------------------------------------------------------------
// dkim_body_canonicalizer
// streaming dkim body canonicalization, simple and relaxed
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | in        | i_in_valid / o_in_stall  | i_command, i_data_byte
//   out     | out       | o_out_valid / i_out_stall| o_item_kind, o_out_byte,
//           |           |                        | o_break_count, o_is_last
//   cfg     | in        | i_cfg_valid / o_cfg_ready| i_cfg_data (relaxed mode)
//
// one input byte is taken per cycle while the bundle queue has room
// each input byte causes zero to four output items, one per cycle at
// the output register unless stalled; output items set the sustained rate
// the first item of a byte passes a queue entry, then the output register
// synchronous active-low reset clears line state, queue and output; relaxed
// mode resets to 1
// a stall on the output fills the four-entry queue, then o_in_stall rises
// ----------------------------------------------------------------------------
module dkim_body_canonicalizer #(
    parameter int unsigned BREAK_COUNT_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // body input
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_command,
    input  logic [7:0]                   i_data_byte,
    // canonical output
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_item_kind,
    output logic [7:0]                   o_out_byte,
    output logic [dbc_pkg::COUNT_W-1:0]  o_break_count,
    output logic                         o_is_last,
    // configuration
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_data
);

    // owed break counter width, the count never goes past 16 bits
    localparam int unsigned CNT_W = (BREAK_COUNT_BITS < dbc_pkg::COUNT_W) ?
                                    BREAK_COUNT_BITS : dbc_pkg::COUNT_W;

    logic             accept;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    dbc_pkg::t_bundle bundle;
    dbc_pkg::t_bundle head;

    // register port never waits
    assign o_cfg_ready = 1'b1;

    // a transfer needs a free queue entry, empty bundles are not queued
    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    dbc_front #(
        .CNT_W (CNT_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_command   (i_command),
        .i_data_byte (i_data_byte),
        .o_push      (push),
        .o_bundle    (bundle)
    );

    dbc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .i_pop    (pop),
        .o_full   (full),
        .o_empty  (empty),
        .o_head   (head)
    );

    dbc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_item_kind   (o_item_kind),
        .o_out_byte    (o_out_byte),
        .o_break_count (o_break_count),
        .o_is_last     (o_is_last)
    );

    // final item is always a single crlf run
    property p_last_is_one_break;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_last) |->
            (o_item_kind == dbc_pkg::KIND_RUN) && (o_break_count == 1);
    endproperty
    a_last_is_one_break: assert property (p_last_is_one_break)
        else $error("last item is not a single break");

    // a run item never carries a zero count or a data byte
    property p_run_nonzero;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_item_kind == dbc_pkg::KIND_RUN)) |->
            (o_break_count != 0) && (o_out_byte == 0);
    endproperty
    a_run_nonzero: assert property (p_run_nonzero)
        else $error("run item with zero count");

    // a byte item carries no count and never ends the body
    property p_byte_clean;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_item_kind == dbc_pkg::KIND_BYTE)) |->
            (o_break_count == 0) && !o_is_last;
    endproperty
    a_byte_clean: assert property (p_byte_clean)
        else $error("byte item with count or last flag");

endmodule
